### hdl/rsqc_pkg.sv
// ----------------------------------------------------------------------------
// rsqc_pkg: shared widths, sine table math and saturation for the quad corners
// Holds the field widths of the stream words, the default sine table depth,
// the quarter-wave sine used to build the table and the Q16.8 saturation.
// ----------------------------------------------------------------------------
package rsqc_pkg;

  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned MAG_W   = 16;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 192;

  localparam int unsigned EXT_W  = SIZE_W + SCALE_W;  // half extent before shifts
  localparam int unsigned PROD_W = EXT_W + MAG_W + 1; // extent times signed sine
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned NEG_W  = SUM_W + 1;
  localparam int unsigned FRAC_X = 31;
  localparam int unsigned OFS_W  = NEG_W - FRAC_X;
  localparam int unsigned CSUM_W = OFS_W + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Sine of f * (pi/2) / 16384 for f in 0..16384 as Q15, Taylor terms to x^11.
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned f);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint unsigned rnd;
    x    = (longint'(f) * HALF_PI_Q30) >> 14;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - longint'(term);
    if (acc < 0) begin
      acc = 0;
    end
    rnd = (longint'(acc) + 64'd16384) >> 15;
    return rnd[MAG_W-1:0];
  endfunction

  // Clamp a center-plus-offset sum to the signed Q16.8 range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [CSUM_W-1:0] v);
    logic signed [CSUM_W-1:0] hi;
    logic signed [CSUM_W-1:0] lo;
    hi = CSUM_W'(signed'(24'sh7FFFFF));
    lo = CSUM_W'(signed'(24'sh800000));
    if (v > hi) begin
      return 24'h7FFFFF;
    end else if (v < lo) begin
      return 24'h800000;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

### hdl/rsqc_sine_rom.sv
// ----------------------------------------------------------------------------
// rsqc_sine_rom: quarter-wave sine table with two registered read ports
// Holds sine magnitudes for the first quadrant, endpoints included, and
// returns the entries for the sine and cosine addresses from registers loaded while en_i is high.
// ----------------------------------------------------------------------------
module rsqc_sine_rom #(
  parameter int unsigned DEPTH = rsqc_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [$clog2(DEPTH)-2:0]              addr_s_i,
  input  logic [$clog2(DEPTH)-2:0]              addr_c_i,
  output logic [rsqc_pkg::MAG_W-1:0]            mag_s_o,
  output logic [rsqc_pkg::MAG_W-1:0]            mag_c_o
);
  import rsqc_pkg::*;

  localparam int unsigned QD      = DEPTH / 4;
  localparam int unsigned STEP    = 16384 / QD;
  localparam int unsigned ENTRIES = QD + 1;

  logic [MAG_W-1:0] rom [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
    assign rom[g] = quarter_sine(g * STEP);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_s_o <= rom[addr_s_i];
      mag_c_o <= rom[addr_c_i];
    end
  end

`ifndef NO_ASSERTIONS
  a_addr_s_range: assert property (@(posedge clk_i) en_i |-> (addr_s_i <= QD))
    else $error("sine address beyond the quarter table");
  a_addr_c_range: assert property (@(posedge clk_i) en_i |-> (addr_c_i <= QD))
    else $error("cosine address beyond the quarter table");
  a_quadrant_pair: assert property (@(posedge clk_i)
      en_i |-> (32'(addr_s_i) + 32'(addr_c_i) == QD)
            || (addr_s_i == addr_c_i))
    else $error("sine and cosine addresses are not complementary");
`endif

endmodule

### hdl/rotated_sprite_quad_corners_top.sv
// ----------------------------------------------------------------------------
// rotated_sprite_quad_corners_top: rotated sprite quad corner generator
// Turns one particle (center, edge, scale, two angles) into the four
// corners of its rotated quad in saturated Q16.8 coordinates.
// ----------------------------------------------------------------------------
// Usage:
// One particle word enters on the s_axis channel and one word of four corners
// leaves on the m_axis channel for each of them, in order. There is no
// configuration and no state between particles.
// The datapath is a six-stage pipeline: angle decode and extent multiply,
// sine table read, rotation multiply, corner sums, rounding, then center add
// and saturation into the output register. Throughput is one particle per
// cycle while the receiver does not stall.
// Each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so when the receiver stalls the pipeline fills up its six
// stages and only then drops s_axis_tready; no word is lost or repeated.
// Reset clears all valid bits; s_axis_tready is high from the first cycle.
// The sine table depth must be a power of two between 256 and 4096.
// ----------------------------------------------------------------------------
module rotated_sprite_quad_corners_top #(
  parameter int unsigned SINE_TABLE_DEPTH = rsqc_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // center_x, center_y, edge_size, scale_factor, spin_angle, base_angle
  input  logic [rsqc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y,
  // top_right_x, top_right_y, top_left_x, top_left_y
  output logic [rsqc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import rsqc_pkg::*;

  localparam int unsigned LOG2D  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned AW     = LOG2D - 1;
  localparam int unsigned SHIFT  = ANGLE_W - LOG2D;
  localparam int unsigned NSTAGE = 6;
  localparam logic [AW-1:0] QD_A = AW'(SINE_TABLE_DEPTH / 4);

  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE:0]   rdy;

  always_comb begin
    rdy[NSTAGE] = m_axis_tready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NSTAGE-1];

  // Stage 1: angle decode, extent multiply.
  logic signed [COORD_W-1:0] in_cx, in_cy;
  logic [SIZE_W-1:0]         in_size;
  logic [SCALE_W-1:0]        in_scale;
  logic [ANGLE_W-1:0]        in_spin, in_base, ang_r;
  logic [LOG2D-1:0]          ang_k;
  logic [1:0]                quad;
  logic [AW-2:0]             frac;
  logic [AW-1:0]             addr_s_d, addr_c_d, addr_s_q, addr_c_q;
  logic                      neg_s_d, neg_c_d;

  assign in_cx    = s_axis_tdata[23:0];
  assign in_cy    = s_axis_tdata[47:24];
  assign in_size  = s_axis_tdata[71:48];
  assign in_scale = s_axis_tdata[87:72];
  assign in_spin  = s_axis_tdata[103:88];
  assign in_base  = s_axis_tdata[119:104];

  always_comb begin
    ang_r    = ANGLE_W'(0) - in_spin - in_base;
    ang_k    = ang_r[ANGLE_W-1:SHIFT];
    quad     = ang_k[LOG2D-1:LOG2D-2];
    frac     = ang_k[LOG2D-3:0];
    addr_s_d = quad[0] ? (QD_A - {1'b0, frac}) : {1'b0, frac};
    addr_c_d = quad[0] ? {1'b0, frac} : (QD_A - {1'b0, frac});
    neg_s_d  = quad[1];
    neg_c_d  = quad[1] ^ quad[0];
  end

  logic [EXT_W-1:0]          ext1_q, ext2_q;
  logic signed [COORD_W-1:0] cx1_q, cy1_q, cx2_q, cy2_q, cx3_q, cy3_q;
  logic signed [COORD_W-1:0] cx4_q, cy4_q, cx5_q, cy5_q;
  logic                      neg_s1_q, neg_c1_q, neg_s2_q, neg_c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_s_q <= '0;
      addr_c_q <= '0;
    end else if (rdy[0]) begin
      addr_s_q <= addr_s_d;
      addr_c_q <= addr_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ext1_q   <= EXT_W'(in_size) * EXT_W'(in_scale);
      neg_s1_q <= neg_s_d;
      neg_c1_q <= neg_c_d;
      cx1_q    <= in_cx;
      cy1_q    <= in_cy;
    end
  end

  // Stage 2: sine table read.
  logic [MAG_W-1:0] mag_s, mag_c;

  rsqc_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i    (clk_i),
    .en_i     (rdy[1]),
    .addr_s_i (addr_s_q),
    .addr_c_i (addr_c_q),
    .mag_s_o  (mag_s),
    .mag_c_o  (mag_c)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      ext2_q   <= ext1_q;
      neg_s2_q <= neg_s1_q;
      neg_c2_q <= neg_c1_q;
      cx2_q    <= cx1_q;
      cy2_q    <= cy1_q;
    end
  end

  // Stage 3: rotation products P = H*c and Q = H*s.
  logic signed [PROD_W-1:0] ext_x, sin_x, cos_x, p_q, q_q;

  always_comb begin
    ext_x = signed'(PROD_W'(ext2_q));
    sin_x = neg_s2_q ? -signed'(PROD_W'(mag_s)) : signed'(PROD_W'(mag_s));
    cos_x = neg_c2_q ? -signed'(PROD_W'(mag_c)) : signed'(PROD_W'(mag_c));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      p_q   <= ext_x * cos_x;
      q_q   <= ext_x * sin_x;
      cx3_q <= cx2_q;
      cy3_q <= cy2_q;
    end
  end

  // Stage 4: A = P + Q and B = Q - P.
  logic signed [SUM_W-1:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      a_q   <= SUM_W'(p_q) + SUM_W'(q_q);
      b_q   <= SUM_W'(q_q) - SUM_W'(p_q);
      cx4_q <= cx3_q;
      cy4_q <= cy3_q;
    end
  end

  // Stage 5: round A, -A, B and -B half up to Q16.8.
  localparam logic signed [NEG_W-1:0] HALF   = NEG_W'(64'd1 << (FRAC_X - 1));
  localparam logic signed [NEG_W-1:0] HALF_1 = NEG_W'((64'd1 << (FRAC_X - 1)) + 64'd1);

  logic signed [NEG_W-1:0] a_x, b_x, ra_s, rna_s, rb_s, rnb_s;
  logic signed [OFS_W-1:0] ra_q, rna_q, rb_q, rnb_q;

  always_comb begin
    a_x   = NEG_W'(a_q);
    b_x   = NEG_W'(b_q);
    ra_s  = (a_x + HALF) >>> FRAC_X;
    rna_s = (~a_x + HALF_1) >>> FRAC_X;
    rb_s  = (b_x + HALF) >>> FRAC_X;
    rnb_s = (~b_x + HALF_1) >>> FRAC_X;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      ra_q  <= ra_s[OFS_W-1:0];
      rna_q <= rna_s[OFS_W-1:0];
      rb_q  <= rb_s[OFS_W-1:0];
      rnb_q <= rnb_s[OFS_W-1:0];
      cx5_q <= cx4_q;
      cy5_q <= cy4_q;
    end
  end

  // Stage 6: add the center and saturate.
  logic signed [CSUM_W-1:0] cx_e, cy_e;
  logic [OUT_DATA_W-1:0]    out_d, out_q;

  always_comb begin
    cx_e  = CSUM_W'(cx5_q);
    cy_e  = CSUM_W'(cy5_q);
    out_d = {sat_coord(cy_e + CSUM_W'(rnb_q)),
             sat_coord(cx_e + CSUM_W'(rna_q)),
             sat_coord(cy_e + CSUM_W'(ra_q)),
             sat_coord(cx_e + CSUM_W'(rnb_q)),
             sat_coord(cy_e + CSUM_W'(rb_q)),
             sat_coord(cx_e + CSUM_W'(ra_q)),
             sat_coord(cy_e + CSUM_W'(rna_q)),
             sat_coord(cx_e + CSUM_W'(rb_q))};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted word did not enter the first stage");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[NSTAGE-2] && rdy[NSTAGE-1] |=> m_axis_tvalid)
    else $error("word lost before the output register");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[NSTAGE-2] && !rdy[NSTAGE-2] |=> vld_q[NSTAGE-2] && vld_q[NSTAGE-1])
    else $error("stalled stage dropped its word");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (&vld_q) && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the pipeline is full and stalled");
`endif

endmodule
